### rtl/core/bba_pkg.sv
// bba_pkg: shared types and constants of the bitmap block allocator.
// No dependencies; imported by every other file of the block.
package bba_pkg;

	localparam int unsigned MAX_BLOCKS_DEF = 4096;

	localparam int unsigned BLK_W = 21;   // block number / granted block
	localparam int unsigned DS_W  = 20;   // data_start register
	localparam int unsigned NB_W  = 13;   // num_data_blocks register
	localparam int unsigned APB_AW = 3;   // two 32-bit registers
	localparam int unsigned APB_DW = 32;

	localparam logic [7:0] FULL_BYTE = 8'hff;
	localparam int unsigned BITS_PER_BYTE = 8;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic REG_DATA_START = 1'b0;
	localparam logic REG_NUM_BLOCKS = 1'b1;

	localparam logic [DS_W-1:0] DATA_START_RST = '0;
	localparam logic [NB_W-1:0] NUM_BLOCKS_RST = NB_W'(4096);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture request
		logic issue;    // scan: read byte at scan pointer, advance
		logic commit;   // scan: set the found bit, grant
		logic free_rd;  // free: read target byte
		logic free_wr;  // free: clear target bit
		logic push;     // move result to output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_free;
		logic req_in_range;
		logic more;      // scan pointer still inside managed bytes
		logic hit;       // byte under test has a usable clear bit
		logic out_busy;  // output register holds an untaken result
	} dp_stat_t;

endpackage

### rtl/core/bba_if.sv
// bba_req_if / bba_rsp_if: valid/ready channels of the allocator.
// Depends on bba_pkg.
interface bba_req_if import bba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             command;
	logic [BLK_W-1:0] block_number;

	modport source(output valid, command, block_number, input ready);
	modport sink(input valid, command, block_number, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
	logic             valid;
	logic             ready;
	status_t          status;
	logic [BLK_W-1:0] granted_block;

	modport source(output valid, status, granted_block, input ready);
	modport sink(input valid, status, granted_block, output ready);
endinterface

### rtl/core/bba_datapath.sv
// bba_datapath: bitmap memory, fill mark, scan pointer, bit search and result registers.
// Depends on bba_pkg; driven by bba_ctrl.
module bba_datapath
	import bba_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic             req_command,
	input  logic [BLK_W-1:0] req_block_number,
	input  logic [DS_W-1:0]  data_start,
	input  logic [NB_W-1:0]  num_data_blocks,
	input  logic             out_ready,
	output logic             out_valid,
	output status_t          out_status,
	output logic [BLK_W-1:0] out_granted
);

	localparam int unsigned MAP_BYTES = (MAX_BLOCKS + 7) / 8;
	localparam int unsigned ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int unsigned HWM_W = $clog2(MAP_BYTES + 1);
	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS + 1);

	logic [7:0] mem [MAP_BYTES];

	logic [IDX_W-1:0] n_q, fidx_q;
	logic [HWM_W-1:0] ptr_q, hwm_q, rd_addr_q;
	logic             rvalid_q, zero_q;
	logic [7:0]       mem_rd_q;
	status_t          res_status_q;
	logic [BLK_W-1:0] res_granted_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [BLK_W-1:0] out_granted_q;

	logic [BLK_W-1:0] num_ext, cap, n_w, ds_ext, diff, grant_w;
	logic             in_range_w;
	logic [IDX_W:0]   n_round;
	logic [7:0]       byte_val, lim, masked, wdata;
	logic [2:0]       fz;
	logic [HWM_W-1:0] free_byte, rd_sel;
	logic             re, we, more, hit;

	// request decode
	assign num_ext    = BLK_W'(num_data_blocks);
	assign cap        = BLK_W'(MAX_BLOCKS);
	assign n_w        = (num_ext > cap) ? cap : num_ext;
	assign ds_ext     = BLK_W'(data_start);
	assign diff       = req_block_number - ds_ext;
	assign in_range_w = (req_block_number >= ds_ext) && (diff < n_w);

	// scan limit: bytes that hold at least one managed bit
	assign n_round = {1'b0, n_q} + (IDX_W + 1)'(7);
	assign more    = BLK_W'(ptr_q) < BLK_W'(n_round[IDX_W:3]);

	// bytes at or past the fill mark were never written: they read as free
	assign byte_val = zero_q ? 8'h00 : mem_rd_q;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			lim[k] = BLK_W'({rd_addr_q, 3'(k)}) >= BLK_W'(n_q);
		end
		masked = byte_val | lim;
		fz = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (!masked[k]) begin
				fz = 3'(k);
			end
		end
	end

	assign hit     = rvalid_q && (masked != FULL_BYTE);
	assign grant_w = ds_ext + BLK_W'({rd_addr_q, fz});

	assign free_byte = HWM_W'(fidx_q[IDX_W-1:3]);
	assign rd_sel    = cmd.free_rd ? free_byte : ptr_q;
	assign re        = cmd.issue | cmd.free_rd;
	assign we        = cmd.commit | cmd.free_wr;
	assign wdata     = cmd.commit ? (byte_val | (8'b1 << fz))
	                              : (byte_val & ~(8'b1 << fidx_q[2:0]));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[rd_addr_q[ADDR_W-1:0]] <= wdata;
		end
		if (re) begin
			mem_rd_q <= mem[rd_sel[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			hwm_q       <= '0;
			rvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_q <= re;
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.issue) begin
				ptr_q <= ptr_q + HWM_W'(1);
			end
			if (cmd.commit && (rd_addr_q == hwm_q)) begin
				hwm_q <= hwm_q + HWM_W'(1);
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q           <= n_w[IDX_W-1:0];
			fidx_q        <= diff[IDX_W-1:0];
			res_granted_q <= '0;
			if (req_command == CMD_FREE) begin
				res_status_q <= in_range_w ? ST_OK : ST_RANGE;
			end else begin
				res_status_q <= ST_FULL;
			end
		end else if (cmd.commit) begin
			res_status_q  <= ST_OK;
			res_granted_q <= grant_w;
		end
		if (re) begin
			rd_addr_q <= rd_sel;
			zero_q    <= rd_sel >= hwm_q;
		end
		if (cmd.push) begin
			out_status_q  <= res_status_q;
			out_granted_q <= res_granted_q;
		end
	end

	assign stat.req_free     = req_command == CMD_FREE;
	assign stat.req_in_range = in_range_w;
	assign stat.more         = more;
	assign stat.hit          = hit;
	assign stat.out_busy     = out_valid_q && !out_ready;

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_granted = out_granted_q;

endmodule

### rtl/core/bba_ctrl.sv
// bba_ctrl: sequencer of the allocator (accept, scan, free, hand off).
// Depends on bba_pkg; drives bba_datapath.
module bba_ctrl
	import bba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_RD,
		S_FREE_WR,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_ready = state_q == S_IDLE;
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = accept;
				if (accept) begin
					if (!stat.req_free) begin
						state_d = S_SCAN;
					end else if (stat.req_in_range) begin
						state_d = S_FREE_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				cmd.issue  = stat.more && !stat.hit;
				cmd.commit = stat.hit;
				if (stat.hit || !stat.more) begin
					state_d = S_DONE;
				end
			end
			S_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_d = S_FREE_WR;
			end
			S_FREE_WR: begin
				cmd.free_wr = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.push = !stat.out_busy;
				if (!stat.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/bitmap_block_allocator.sv
// bitmap_block_allocator: top level, APB register file, controller and datapath.
// Depends on bba_pkg, bba_if, bba_ctrl, bba_datapath.
//
// First-fit block allocator over a bitmap of one bit per managed block. An
// allocate request grants data_start plus the lowest clear index below
// min(num_data_blocks, MAX_BLOCKS) and sets that bit; with none left it
// answers status 1 and granted_block 0. A free request clears the bit of an
// absolute block number; a number outside the managed window answers status
// 2 and changes nothing. Every request gives one response. The bitmap is a
// byte-wide single-port memory; a fill mark tracks the highest byte ever
// written, so bytes past it read as free and no clearing pass follows reset.
// Timing: the scan reads one bitmap byte per cycle through the memory's
// registered read port and stops at the first byte with a usable clear bit
// or past the last managed byte; an in-range free reads its byte, then
// writes it back with the bit cleared, and an out-of-range free goes straight
// to the response. A response still waiting in the output register holds the
// next one back for as long as it waits. One request is in flight at a time,
// but a finished response waits in the output register while the next
// request is accepted. Registers: data_start at 0x0, num_data_blocks at
// 0x4; write them only while no request is in flight.
module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	bba_req_if.sink           req,
	bba_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [DS_W-1:0] data_start_q;
	logic [NB_W-1:0] num_blocks_q;
	logic            cfg_wr;
	dp_cmd_t         cmd;
	dp_stat_t        stat;

	// APB: no wait states; the register index is the word address
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= DATA_START_RST;
			num_blocks_q <= NUM_BLOCKS_RST;
		end else if (cfg_wr) begin
			if (paddr[APB_AW-1] == REG_DATA_START) begin
				data_start_q <= pwdata[DS_W-1:0];
			end else begin
				num_blocks_q <= pwdata[NB_W-1:0];
			end
		end
	end

	assign prdata = (paddr[APB_AW-1] == REG_NUM_BLOCKS) ? APB_DW'(num_blocks_q)
	                                                    : APB_DW'(data_start_q);

	// sequencer: one request at a time
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// bitmap, scan and response register
	bba_datapath #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.req_command      (req.command),
		.req_block_number (req.block_number),
		.data_start       (data_start_q),
		.num_data_blocks  (num_blocks_q),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.out_status       (rsp.status),
		.out_granted      (rsp.granted_block)
	);

	// a request is never taken twice in a row: work follows each accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous one in progress");

	// only a successful allocate carries a block number
	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != ST_OK) |-> rsp.granted_block == '0)
		else $error("nonzero granted_block on failed request");

	// a response appears only after an accepted request
	a_rsp_needs_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> !req.ready || $past(!req.ready))
		else $error("response without a request");

endmodule

### test/tb_bitmap_block_allocator.sv
`timescale 1ns / 100ps
// tb_bitmap_block_allocator: self-checking testbench of the first-fit block allocator.
// Depends on bba_pkg, bba_if and bitmap_block_allocator.
module tb_bitmap_block_allocator
	import bba_pkg::*;
();

	localparam int unsigned CAP         = MAX_BLOCKS_DEF;
	localparam int unsigned STALL_LIMIT = 4000;	// cycles with no handshake at all
	localparam int unsigned PRINT_CAP   = 40;	// mismatch lines printed, the rest only counted

	typedef struct {
		logic             command;
		logic [BLK_W-1:0] block_number;
	} request_t;

	typedef struct {
		status_t          status;
		logic [BLK_W-1:0] granted_block;
	} response_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bba_req_if req_ch ();
	bba_rsp_if rsp_ch ();

	bitmap_block_allocator #(.MAX_BLOCKS(CAP)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Requests waiting for the driver, and responses predicted at request accept.
	request_t  request_q[$];
	response_t response_q[$];

	// Shadow of the allocator: window registers and the usage map.
	// A set bit is a block in use. Like the block, the map is kept across
	// window changes; only reset clears it.
	logic [DS_W-1:0] shadow_start;
	logic [NB_W-1:0] shadow_count;
	logic [CAP-1:0]  in_use;

	int unsigned req_offered;	// requests put on the channel by the driver
	int unsigned req_taken;	// requests accepted by the block
	int unsigned moves;	// handshakes of either channel, for the watchdog
	int unsigned mismatches;
	int unsigned req_gap;
	int unsigned rsp_hold;
	bit          calm;	// no idling on either side while set

	int unsigned n_grants;
	int unsigned n_full;
	int unsigned n_range;
	int unsigned n_freed;
	int unsigned n_windows;

	always #2 clk = ~clk;

	// Blocks managed under the current window: the count saturates at capacity.
	function automatic int unsigned managed_span();
		return (int'(shadow_count) > CAP) ? CAP : int'(shadow_count);
	endfunction

	// First-fit prediction: lowest clear index for an allocate, bit clear for
	// a free inside the window, out-of-range status otherwise.
	function automatic response_t first_fit_outcome(input logic cmd,
			input logic [BLK_W-1:0] blk);
		response_t   res;
		int unsigned span;
		int unsigned offs;
		span = managed_span();
		res.status = ST_OK;
		res.granted_block = '0;
		if (cmd == CMD_ALLOC) begin
			res.status = ST_FULL;
			for (int unsigned slot = 0; slot < span; slot++) begin
				if (!in_use[slot]) begin
					in_use[slot] = 1'b1;
					res.status = ST_OK;
					res.granted_block = BLK_W'(int'(shadow_start) + slot);
					break;
				end
			end
		end else if (int'(blk) < int'(shadow_start)) begin
			res.status = ST_RANGE;
		end else begin
			offs = int'(blk) - int'(shadow_start);
			if (offs >= span) begin
				res.status = ST_RANGE;
			end else begin
				in_use[offs] = 1'b0;	// clearing a clear bit is legal too
			end
		end
		return res;
	endfunction

	function automatic bit all_quiet();
		return request_q.size() == 0 && req_taken == req_offered && response_q.size() == 0;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	task automatic queue_request(input logic cmd, input int unsigned blk);
		request_t item;
		item.command = cmd;
		item.block_number = BLK_W'(blk);
		request_q.push_back(item);
	endtask

	// Sender pause: hold off until every predicted response has come back,
	// then let the block settle before returning.
	task automatic drain();
		while (!all_quiet()) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register loads at the
	// edge where psel, penable, pwrite and pready are all high.
	task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_DATA_START) begin
			shadow_start = value[DS_W-1:0];
		end else begin
			shadow_count = value[NB_W-1:0];
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Registers change only with the block idle.
	task automatic set_window(input int unsigned start, input int unsigned count);
		drain();
		write_reg(REG_DATA_START, APB_DW'(start));
		write_reg(REG_NUM_BLOCKS, APB_DW'(count));
		n_windows++;
	endtask

	// Random mix for the current window. Mostly allocates and frees of blocks
	// inside the window, so the map fills, runs full and drains again; the
	// rest are frees just outside the window edges or anywhere at all.
	task automatic queue_mix(input int unsigned count);
		int unsigned span;
		int unsigned pick;
		int unsigned blk;
		span = managed_span();
		for (int unsigned k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			blk = $urandom;
			if (pick < 55) begin
				queue_request(CMD_ALLOC, blk);
			end else begin
				if (pick < 88 && span != 0) begin
					blk = shadow_start + $urandom_range(0, span - 1);
				end else if (pick < 94) begin
					blk = $urandom_range(0, 1) ? shadow_start + span : shadow_start - 1;
				end
				queue_request(CMD_FREE, blk);
			end
		end
	endtask

	// Request driver: changes at the falling edge, holds an offered request
	// until it is taken, and inserts random idle bursts.
	always @(negedge clk) begin
		request_t nxt;
		logic     drive;
		drive = req_ch.valid;
		if (!arst_n) begin
			drive = 1'b0;
		end else if (!(req_ch.valid && req_taken != req_offered)) begin
			if (req_gap != 0) begin
				req_gap--;
				drive = 1'b0;
			end else if (!calm && request_q.size() != 0 && $urandom_range(0, 7) == 0) begin
				req_gap = $urandom_range(0, 9);
				drive = 1'b0;
			end else if (request_q.size() != 0) begin
				nxt = request_q.pop_front();
				req_ch.command      <= nxt.command;
				req_ch.block_number <= nxt.block_number;
				drive = 1'b1;
				req_offered++;
			end else begin
				drive = 1'b0;
			end
		end
		req_ch.valid <= drive;
	end

	// Response sink: ready drops in random bursts.
	always @(negedge clk) begin
		logic take;
		take = 1'b1;
		if (!arst_n) begin
			take = 1'b0;
		end else if (rsp_hold != 0) begin
			rsp_hold--;
			take = 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			rsp_hold = $urandom_range(0, 9);
			take = 1'b0;
		end
		rsp_ch.ready <= take;
	end

	// Monitor: predicts on each accepted request, checks each accepted
	// response against the oldest prediction.
	always @(posedge clk) begin
		response_t due;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				response_q.push_back(first_fit_outcome(req_ch.command, req_ch.block_number));
				req_taken++;
				moves++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				moves++;
				if (response_q.size() == 0) begin
					flag_mismatch($sformatf("response with no request outstanding, status %0d",
						rsp_ch.status));
				end else begin
					due = response_q.pop_front();
					if (rsp_ch.status !== due.status) begin
						flag_mismatch($sformatf("status %0d, predicted %0d",
							rsp_ch.status, due.status));
					end
					if (rsp_ch.granted_block !== due.granted_block) begin
						flag_mismatch($sformatf("granted_block 0x%0h, predicted 0x%0h",
							rsp_ch.granted_block, due.granted_block));
					end
					case (due.status)
						ST_OK:    n_grants++;
						ST_FULL:  n_full++;
						ST_RANGE: n_range++;
						default:  ;
					endcase
				end
			end
		end
	end

	// Watchdog, sampled at the falling edge so it never races the monitor.
	int unsigned seen_moves;
	int unsigned quiet;
	always @(negedge clk) begin
		if (moves != seen_moves) begin
			seen_moves = moves;
			quiet = 0;
		end else if (arst_n) begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("[%0t] watchdog: no handshake for %0d cycles", $realtime, quiet);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned start;
		int unsigned count;
		int unsigned last;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ALLOC;
		req_ch.block_number = '0;
		rsp_ch.ready = 1'b0;
		shadow_start = DATA_START_RST;
		shadow_count = NUM_BLOCKS_RST;
		in_use = '0;
		calm = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset window: block zero granted with status ok, double free,
		// frees beyond the window up to the largest block number.
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_ALLOC, 21'h1fffff);
		queue_request(CMD_FREE, 0);
		queue_request(CMD_FREE, 0);
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_FREE, CAP);
		queue_request(CMD_FREE, 21'h1fffff);
		queue_request(CMD_FREE, CAP - 1);
		queue_request(CMD_ALLOC, 0);

		// Eight-block window with its low bits already taken: runs full,
		// then frees just below, at and inside the upper edge.
		set_window(1000, 8);
		repeat (6) queue_request(CMD_ALLOC, 0);
		queue_request(CMD_FREE, 999);
		queue_request(CMD_FREE, 1008);
		queue_request(CMD_FREE, 1007);
		queue_request(CMD_ALLOC, 0);

		// Empty window: nothing to allocate, every free out of range.
		set_window(1000, 0);
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_FREE, 1000);

		// Largest start with a count above capacity: the window saturates.
		set_window(20'hfffff, 13'h1fff);
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_FREE, 20'hfffff + CAP - 1);
		queue_request(CMD_FREE, 20'hfffff + CAP);

		// Random windows, mostly small so scans stay short; every fourth
		// window and the final one run with both sides always ready.
		last = 14;
		for (int unsigned p = 0; p <= last; p++) begin
			start = $urandom_range(0, 3) == 0 ? $urandom_range(0, 64) : $urandom & 20'hfffff;
			case ($urandom_range(0, 9))
				0:       count = 0;
				1:       count = CAP;
				2:       count = $urandom_range(CAP + 1, 8191);
				3:       count = $urandom & 13'h1fff;
				default: count = $urandom_range(1, 120);
			endcase
			set_window(start, count);
			calm = (p % 4 == 3) || (p == last);
			if (p % 5 == 2) begin
				// sender holds off mid-window until every response is back
				queue_mix(48);
				drain();
				queue_mix(47);
			end else begin
				queue_mix(95);
			end
		end

		while (!all_quiet()) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);

		$display("Covered %0d requests over %0d windows: %0d grants, %0d map-full answers,",
			req_taken, n_windows + 1, n_grants, n_full);
		$display("%0d out-of-range frees, %0d mismatches.", n_range, mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
